>>> hdl/mmtm_pkg.sv
// Shared types and constants for the transposing matrix multiply block.
// Used by the channel interfaces, the controller, the datapath and the top level.
`timescale 1ns / 1ps

package mmtm_pkg;

   // sizing
   localparam int MAX_DIM     = 8;
   localparam int FRAC_BITS   = 16;
   localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int DIM_W       = $clog2(MAX_DIM + 1);
   localparam int CNT_W       = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

   // field widths fixed by the interface
   localparam int OP_W       = 2;
   localparam int IDX_W      = 6;
   localparam int ELEM_W     = 32;
   localparam int COORD_W    = 3;
   localparam int DIMREG_W   = 4;
   localparam int MODE_W     = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 4;

   // arithmetic widths
   localparam int PROD_W = 2 * ELEM_W;
   localparam int ACC_W  = PROD_W + $clog2(MAX_DIM) + 2;

   // opcodes
   localparam logic [OP_W-1:0] OP_LOAD_LEFT  = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD_RIGHT = 2'd1;
   localparam logic [OP_W-1:0] OP_COMPUTE    = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_ROWS  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_COLS  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_ROWS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_COLS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE       = 3'd4;

   // command from controller to datapath
   typedef struct packed {
      logic              wr_left;
      logic              wr_right;
      logic [ADDR_W-1:0] wr_addr;
      logic              rd_en;
      logic [ADDR_W-1:0] left_addr;
      logic [ADDR_W-1:0] right_addr;
      logic              first;
      logic              last;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic              last_elem;
      logic              err_load;
   } mmtm_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic pipe_busy;
      logic out_free;
   } mmtm_stat_type;

endpackage

>>> hdl/mmtm_if.sv
// Valid/ready channel interfaces for request items and result items.
// Depends on mmtm_pkg for the field widths.
`timescale 1ns / 1ps

interface mmtm_req_if import mmtm_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          opcode;
   logic [IDX_W-1:0]         element_index;
   logic signed [ELEM_W-1:0] element_value;

   modport source (output valid, output opcode, output element_index,
                   output element_value, input ready);
   modport sink   (input valid, input opcode, input element_index,
                   input element_value, output ready);
endinterface

interface mmtm_rsp_if import mmtm_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [ELEM_W-1:0] product_value;
   logic [COORD_W-1:0]       out_row;
   logic [COORD_W-1:0]       out_col;
   logic                     dimension_error;
   logic                     saturated;
   logic                     last;

   modport source (output valid, output product_value, output out_row, output out_col,
                   output dimension_error, output saturated, output last, input ready);
   modport sink   (input valid, input product_value, input out_row, input out_col,
                   input dimension_error, input saturated, input last, output ready);
endinterface

>>> hdl/mmtm_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mmtm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> hdl/mmtm_dpath.sv
// Datapath: left and right element stores, one pipelined multiply-accumulate,
// rounding and saturation, and the result output register. Uses mmtm_pkg and mmtm_ram.
`timescale 1ns / 1ps

module mmtm_dpath import mmtm_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  mmtm_cmd_type             cmd,
   input  logic signed [ELEM_W-1:0] wr_data,
   output mmtm_stat_type            stat,
   mmtm_rsp_if.source               rsp_chan
);

   localparam logic [ACC_W-1:0] ROUND_HALF =
      (FRAC_BITS > 0) ? (ACC_W'(1) << (FRAC_BITS - 1)) : '0;

   logic [ELEM_W-1:0] left_rdata;
   logic [ELEM_W-1:0] right_rdata;

   // stage one tags, alongside the ram read data
   logic               s1_valid_ff, s1_first_ff, s1_last_ff, s1_lastel_ff;
   logic [COORD_W-1:0] s1_row_ff, s1_col_ff;
   // stage two: product
   logic               s2_valid_ff, s2_first_ff, s2_last_ff, s2_lastel_ff;
   logic [COORD_W-1:0] s2_row_ff, s2_col_ff;
   logic signed [PROD_W-1:0] prod_ff;
   // stage three: accumulator
   logic               s3_valid_ff, s3_last_ff, s3_lastel_ff;
   logic [COORD_W-1:0] s3_row_ff, s3_col_ff;
   logic signed [ACC_W-1:0] acc_ff, acc_in;

   // finishing logic
   logic signed [ACC_W-1:0] rnd_sum;
   logic signed [ACC_W-1:0] rnd_shift;
   logic                    in_range;
   logic [ELEM_W-1:0]       fin_value;
   logic                    fin_valid;

   // output register
   logic                     out_valid_ff;
   logic signed [ELEM_W-1:0] out_value_ff;
   logic [COORD_W-1:0]       out_row_ff, out_col_ff;
   logic                     out_err_ff, out_sat_ff, out_last_ff;

   // element stores
   mmtm_ram #(.WIDTH(ELEM_W), .DEPTH(STORE_DEPTH)) u_left_ram (
      .clock (clock),
      .we    (cmd.wr_left),
      .waddr (cmd.wr_addr),
      .wdata (wr_data),
      .re    (cmd.rd_en),
      .raddr (cmd.left_addr),
      .rdata (left_rdata)
   );

   mmtm_ram #(.WIDTH(ELEM_W), .DEPTH(STORE_DEPTH)) u_right_ram (
      .clock (clock),
      .we    (cmd.wr_right),
      .waddr (cmd.wr_addr),
      .wdata (wr_data),
      .re    (cmd.rd_en),
      .raddr (cmd.right_addr),
      .rdata (right_rdata)
   );

   // pipeline valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.rd_en;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // pipeline tags and multiply
   always_ff @(posedge clock) begin
      s1_first_ff  <= cmd.first;
      s1_last_ff   <= cmd.last;
      s1_lastel_ff <= cmd.last_elem;
      s1_row_ff    <= cmd.row;
      s1_col_ff    <= cmd.col;

      s2_first_ff  <= s1_first_ff;
      s2_last_ff   <= s1_last_ff;
      s2_lastel_ff <= s1_lastel_ff;
      s2_row_ff    <= s1_row_ff;
      s2_col_ff    <= s1_col_ff;
      prod_ff      <= $signed(left_rdata) * $signed(right_rdata);

      s3_last_ff   <= s2_last_ff;
      s3_lastel_ff <= s2_lastel_ff;
      s3_row_ff    <= s2_row_ff;
      s3_col_ff    <= s2_col_ff;
   end

   // accumulate, restarting on the first term of an element
   always_comb begin
      acc_in = (s2_first_ff ? '0 : acc_ff)
             + {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   end

   always_ff @(posedge clock) begin
      if (s2_valid_ff) begin
         acc_ff <= acc_in;
      end
   end

   // round half up, drop fraction bits, clip to 32 bits
   always_comb begin
      rnd_sum   = acc_ff + $signed(ROUND_HALF);
      rnd_shift = rnd_sum >>> FRAC_BITS;
      in_range  = (&rnd_shift[ACC_W-1:ELEM_W-1]) | ~(|rnd_shift[ACC_W-1:ELEM_W-1]);
      if (in_range) begin
         fin_value = rnd_shift[ELEM_W-1:0];
      end else if (rnd_shift[ACC_W-1]) begin
         fin_value = {1'b1, {(ELEM_W-1){1'b0}}};
      end else begin
         fin_value = {1'b0, {(ELEM_W-1){1'b1}}};
      end
      fin_valid = s3_valid_ff & s3_last_ff;
   end

   // output register control
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (fin_valid || cmd.err_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   // output register payload
   always_ff @(posedge clock) begin
      if (cmd.err_load) begin
         out_value_ff <= '0;
         out_row_ff   <= '0;
         out_col_ff   <= '0;
         out_err_ff   <= 1'b1;
         out_sat_ff   <= 1'b0;
         out_last_ff  <= 1'b1;
      end else if (fin_valid) begin
         out_value_ff <= fin_value;
         out_row_ff   <= s3_row_ff;
         out_col_ff   <= s3_col_ff;
         out_err_ff   <= 1'b0;
         out_sat_ff   <= ~in_range;
         out_last_ff  <= s3_lastel_ff;
      end
   end

   assign rsp_chan.valid           = out_valid_ff;
   assign rsp_chan.product_value   = out_value_ff;
   assign rsp_chan.out_row         = out_row_ff;
   assign rsp_chan.out_col         = out_col_ff;
   assign rsp_chan.dimension_error = out_err_ff;
   assign rsp_chan.saturated       = out_sat_ff;
   assign rsp_chan.last            = out_last_ff;

   // status back to the controller
   assign stat.pipe_busy = s1_valid_ff | s2_valid_ff | s3_valid_ff;
   assign stat.out_free  = ~out_valid_ff | rsp_chan.ready;

endmodule

>>> hdl/mmtm_ctrl.sv
// Controller: configuration registers, request acceptance and the sequencer that
// walks rows, columns and inner terms of the product. Uses mmtm_pkg.
`timescale 1ns / 1ps

module mmtm_ctrl import mmtm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   mmtm_req_if.sink              req_chan,
   input  mmtm_stat_type         stat,
   output mmtm_cmd_type          cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_START = 2'd1;
   localparam logic [1:0] ST_MAC   = 2'd2;
   localparam logic [1:0] ST_ERR   = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [CNT_W-1:0]    i_ff, i_in, j_ff, j_in, k_ff, k_in;

   logic [DIMREG_W-1:0] left_rows_ff, left_cols_ff, right_rows_ff, right_cols_ff;
   logic [MODE_W-1:0]   mode_ff;

   logic [DIM_W-1:0] lr, lc, rr, rc;
   logic [DIM_W-1:0] er_l, ec_l, er_r, ec_r;
   logic             tl, tr;
   logic             accept, gate;
   logic             k_last, j_last, i_last;

   // clamp a stored dimension into 1 .. MAX_DIM
   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIMREG_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (32'(v) > MAX_DIM) begin
         r = DIM_W'(MAX_DIM);
      end else begin
         r = DIM_W'(v);
      end
      return r;
   endfunction

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         left_rows_ff  <= DIMREG_W'(1);
         left_cols_ff  <= DIMREG_W'(1);
         right_rows_ff <= DIMREG_W'(1);
         right_cols_ff <= DIMREG_W'(1);
         mode_ff       <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LEFT_ROWS:  left_rows_ff  <= csr_wdata;
            CSR_LEFT_COLS:  left_cols_ff  <= csr_wdata;
            CSR_RIGHT_ROWS: right_rows_ff <= csr_wdata;
            CSR_RIGHT_COLS: right_cols_ff <= csr_wdata;
            CSR_MODE:       mode_ff       <= csr_wdata[MODE_W-1:0];
            default: ;
         endcase
      end
   end

   // effective shapes after transposition
   always_comb begin
      lr   = eff_dim(left_rows_ff);
      lc   = eff_dim(left_cols_ff);
      rr   = eff_dim(right_rows_ff);
      rc   = eff_dim(right_cols_ff);
      tr   = mode_ff[0];
      tl   = mode_ff[1];
      er_l = tl ? lc : lr;
      ec_l = tl ? lr : lc;
      er_r = tr ? rc : rr;
      ec_r = tr ? rr : rc;
   end

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid & req_chan.ready;
   // a new element or error result may start once the pipe is empty and the
   // output register will be free
   assign gate           = ~stat.pipe_busy & stat.out_free;

   assign k_last = (DIM_W'(k_ff) + DIM_W'(1)) == ec_l;
   assign j_last = (DIM_W'(j_ff) + DIM_W'(1)) == ec_r;
   assign i_last = (DIM_W'(i_ff) + DIM_W'(1)) == er_l;

   // sequencer and command generation
   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;

      cmd            = '0;
      cmd.wr_addr    = ADDR_W'(req_chan.element_index);
      cmd.left_addr  = tl ? ADDR_W'(ADDR_W'(k_ff) * ADDR_W'(lc) + ADDR_W'(i_ff))
                          : ADDR_W'(ADDR_W'(i_ff) * ADDR_W'(lc) + ADDR_W'(k_ff));
      cmd.right_addr = tr ? ADDR_W'(ADDR_W'(j_ff) * ADDR_W'(rc) + ADDR_W'(k_ff))
                          : ADDR_W'(ADDR_W'(k_ff) * ADDR_W'(rc) + ADDR_W'(j_ff));
      cmd.first      = (k_ff == '0);
      cmd.last       = k_last;
      cmd.row        = COORD_W'(i_ff);
      cmd.col        = COORD_W'(j_ff);
      cmd.last_elem  = i_last & j_last;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_chan.opcode)
                  OP_LOAD_LEFT: begin
                     cmd.wr_left = (32'(req_chan.element_index) < STORE_DEPTH);
                  end
                  OP_LOAD_RIGHT: begin
                     cmd.wr_right = (32'(req_chan.element_index) < STORE_DEPTH);
                  end
                  OP_COMPUTE: begin
                     i_in = '0;
                     j_in = '0;
                     k_in = '0;
                     state_in = (ec_l != er_r) ? ST_ERR : ST_START;
                  end
                  default: ;
               endcase
            end
         end
         ST_ERR: begin
            if (gate) begin
               cmd.err_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_START: begin
            if (gate) begin
               k_in     = '0;
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            cmd.rd_en = 1'b1;
            if (k_last) begin
               k_in = '0;
               if (j_last) begin
                  j_in = '0;
                  if (i_last) begin
                     state_in = ST_IDLE;
                  end else begin
                     i_in     = i_ff + CNT_W'(1);
                     state_in = ST_START;
                  end
               end else begin
                  j_in     = j_ff + CNT_W'(1);
                  state_in = ST_START;
               end
            end else begin
               k_in = k_ff + CNT_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
      end
   end

endmodule

>>> hdl/matrix_multiply_transpose_modes.sv
// Top level of the transposing matrix multiply block.
// Depends on mmtm_pkg, mmtm_if, mmtm_ctrl, mmtm_dpath and mmtm_ram.
`timescale 1ns / 1ps

// Matrix multiply with optional transposition of either operand on Q16.16
// elements. Load items write one element of the left or right store and give
// no result. A compute item forms op(L) * op(R) with a single multiply-accumulate
// unit fed from the two stores; an element starts only once the pipeline is
// empty and the output register will be free, and its n store reads, where n
// is the inner dimension, pass through three pipeline stages (read, product,
// accumulate). Results are emitted row by row from an output register, the
// last one marked; an inner dimension mismatch gives one result with the
// error flag set. Sums are kept exact, rounded half up and clipped to 32 bits.
// Stores hold no reset value and every element read must have been loaded
// first. Configuration must be written through the csr port only while the
// block is idle; the block itself does not enforce this.
module matrix_multiply_transpose_modes import mmtm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   mmtm_req_if.sink              req_chan,
   mmtm_rsp_if.source            rsp_chan
);

   mmtm_cmd_type  cmd;
   mmtm_stat_type stat;

   // controller
   mmtm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_chan),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath
   mmtm_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .wr_data  (req_chan.element_value),
      .stat     (stat),
      .rsp_chan (rsp_chan)
   );

endmodule

>>> sim/matrix_multiply_transpose_modes_checker.sv
// Result checker for the transposing matrix multiply block.
// Watches the csr port and both channels, predicts each product and compares item by item.
// Depends on mmtm_pkg and the channel interfaces in mmtm_if.
`timescale 1ns / 1ps

module matrix_multiply_transpose_modes_checker import mmtm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   mmtm_req_if                   req_mon,
   mmtm_rsp_if                   rsp_mon,
   output int unsigned           failures,
   output int unsigned           outstanding
);

   // one expected product element
   typedef struct {
      logic signed [ELEM_W-1:0] value;
      logic [COORD_W-1:0]       row, col;
      logic                     dim_err, sat, last;
   } product_elem_type;

   localparam logic signed [127:0] ROUND_HALF = 128'sd1 <<< (FRAC_BITS - 1);
   localparam logic signed [127:0] Q_MAX      = 128'sh7FFF_FFFF;
   localparam logic signed [127:0] Q_MIN      = -128'sh8000_0000;

   logic signed [ELEM_W-1:0] left_mem  [STORE_DEPTH];
   logic signed [ELEM_W-1:0] right_mem [STORE_DEPTH];
   logic [DIMREG_W-1:0]      left_rows_reg, left_cols_reg, right_rows_reg, right_cols_reg;
   logic [MODE_W-1:0]        mode_reg;
   product_elem_type         pending_products [$];
   int unsigned              fail_count = 0;
   int unsigned              pending_count = 0;

   assign failures    = fail_count;
   assign outstanding = pending_count;

   // zero reads as one, anything above the maximum as the maximum
   function automatic int unsigned clamp_dim(input logic [DIMREG_W-1:0] raw);
      if (raw == 0) return 1;
      if (raw > MAX_DIM) return MAX_DIM;
      return 32'(raw);
   endfunction

   // op(L) * op(R), exact sum, rounded half up and clipped to 32 bits
   task automatic predict_product();
      int unsigned   lr, lc, rr, rc, m, n, inner_r, p, li, ri;
      logic          tl, tr;
      logic signed [127:0] acc, term;
      longint        prod;
      product_elem_type elem;
      lr = clamp_dim(left_rows_reg);
      lc = clamp_dim(left_cols_reg);
      rr = clamp_dim(right_rows_reg);
      rc = clamp_dim(right_cols_reg);
      tr = mode_reg[0];
      tl = mode_reg[1];
      m       = tl ? lc : lr;
      n       = tl ? lr : lc;
      inner_r = tr ? rc : rr;
      p       = tr ? rr : rc;
      // inner dimensions disagree: a single flagged item
      if (n != inner_r) begin
         elem = '{value: '0, row: '0, col: '0, dim_err: 1'b1, sat: 1'b0, last: 1'b1};
         pending_products = {pending_products, elem};
         return;
      end
      for (int i = 0; i < m; i++) begin
         for (int j = 0; j < p; j++) begin
            acc = '0;
            for (int k = 0; k < n; k++) begin
               li   = tl ? (k * lc + i) : (i * lc + k);
               ri   = tr ? (j * rc + k) : (k * rc + j);
               prod = longint'(left_mem[li % STORE_DEPTH]) * longint'(right_mem[ri % STORE_DEPTH]);
               term = prod;
               acc  = acc + term;
            end
            acc = (acc + ROUND_HALF) >>> FRAC_BITS;
            elem.sat = 1'b1;
            if (acc > Q_MAX) elem.value = 32'sh7FFF_FFFF;
            else if (acc < Q_MIN) elem.value = 32'sh8000_0000;
            else begin
               elem.value = acc[ELEM_W-1:0];
               elem.sat   = 1'b0;
            end
            elem.row     = COORD_W'(i);
            elem.col     = COORD_W'(j);
            elem.dim_err = 1'b0;
            elem.last    = (i == m - 1) && (j == p - 1);
            pending_products = {pending_products, elem};
         end
      end
   endtask

   task automatic check_field(input string field, input logic signed [63:0] want,
                              input logic signed [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         fail_count++;
      end
   endtask

   // watch the csr port and both channels
   always @(posedge clock) begin
      product_elem_type want;
      if (reset) begin
         left_rows_reg  = DIMREG_W'(1);
         left_cols_reg  = DIMREG_W'(1);
         right_rows_reg = DIMREG_W'(1);
         right_cols_reg = DIMREG_W'(1);
         mode_reg       = '0;
         pending_products.delete();
      end else begin
         // result items against the oldest expectation
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_products.size() == 0) begin
               $error("unexpected result item: product_value %0d row %0d col %0d",
                      rsp_mon.product_value, rsp_mon.out_row, rsp_mon.out_col);
               fail_count++;
            end else begin
               want = pending_products.pop_front();
               check_field("product_value", want.value, rsp_mon.product_value);
               check_field("out_row", want.row, rsp_mon.out_row);
               check_field("out_col", want.col, rsp_mon.out_col);
               check_field("dimension_error", want.dim_err, rsp_mon.dimension_error);
               check_field("saturated", want.sat, rsp_mon.saturated);
               check_field("last", want.last, rsp_mon.last);
            end
         end
         // register writes, only ever made while idle
         if (csr_we) begin
            case (csr_index)
               CSR_LEFT_ROWS:  left_rows_reg  = csr_wdata;
               CSR_LEFT_COLS:  left_cols_reg  = csr_wdata;
               CSR_RIGHT_ROWS: right_rows_reg = csr_wdata;
               CSR_RIGHT_COLS: right_cols_reg = csr_wdata;
               CSR_MODE:       mode_reg       = csr_wdata[MODE_W-1:0];
               default: ;
            endcase
         end
         // request items
         if (req_mon.valid && req_mon.ready) begin
            case (req_mon.opcode)
               OP_LOAD_LEFT:  left_mem[req_mon.element_index]  = req_mon.element_value;
               OP_LOAD_RIGHT: right_mem[req_mon.element_index] = req_mon.element_value;
               OP_COMPUTE:    predict_product();
               default: ;
            endcase
         end
      end
      pending_count <= pending_products.size();
   end

endmodule

>>> sim/matrix_multiply_transpose_modes_test.sv
// Testbench top for the transposing matrix multiply block: clock, reset, csr writes and stimulus.
// Directed corner cases first, then random phases of settings with loads and products.
// Depends on mmtm_pkg, mmtm_if, the block itself and matrix_multiply_transpose_modes_checker.
`timescale 1ns / 1ps

module matrix_multiply_transpose_modes_test;
   import mmtm_pkg::*;

   localparam logic [OP_W-1:0]      OP_UNUSED = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_NONE  = 3'd7;
   localparam int ITEM_COUNT   = 200;
   localparam int DRAIN_CYCLES = 16;

   typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_PERIODIC} stall_kind_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int unsigned           failures;
   int unsigned           outstanding;

   mmtm_req_if req_chan ();
   mmtm_rsp_if rsp_chan ();

   matrix_multiply_transpose_modes i_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan)
   );

   matrix_multiply_transpose_modes_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .failures    (failures),
      .outstanding (outstanding)
   );

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver stalls, switching pattern every so often
   stall_kind_type stall_mode = STALL_NONE;
   int unsigned stall_span = 40;
   logic [2:0]  stall_tick = '0;

   always @(posedge clock) begin
      stall_tick <= stall_tick + 3'd1;
      if (stall_span == 0) begin
         stall_mode <= stall_kind_type'($urandom_range(0, 2));
         stall_span <= $urandom_range(16, 160);
      end else begin
         stall_span <= stall_span - 1;
      end
      case (stall_mode)
         STALL_NONE:   rsp_chan.ready <= 1'b1;
         STALL_RANDOM: rsp_chan.ready <= ($urandom_range(0, 2) != 0);
         default:      rsp_chan.ready <= (stall_tick < 3'd5);
      endcase
   end

   // sender state
   int unsigned burst_left = 0;
   int unsigned sent_count = 0;
   bit          left_written  [STORE_DEPTH];
   bit          right_written [STORE_DEPTH];
   int unsigned left_size  = 1;
   int unsigned right_size = 1;

   // one item on the request channel, bursts with random gaps between them
   task automatic send_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                            input logic signed [ELEM_W-1:0] val);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
         if (gap != 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      req_chan.valid         <= 1'b1;
      req_chan.opcode        <= op;
      req_chan.element_index <= idx;
      req_chan.element_value <= val;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      burst_left--;
      sent_count++;
   endtask

   task automatic load_elem(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                            input logic signed [ELEM_W-1:0] val);
      send_item(op, idx, val);
      if (op == OP_LOAD_LEFT) left_written[idx] = 1'b1;
      else right_written[idx] = 1'b1;
   endtask

   // mix of extremes, full-range and sign-extended narrower values
   function automatic logic signed [ELEM_W-1:0] random_value();
      logic [31:0] raw;
      raw = $urandom;
      case ($urandom_range(0, 7))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2, 3:    return raw;
         4, 5:    return {{4{raw[27]}}, raw[27:0]};
         default: return {{12{raw[19]}}, raw[19:0]};
      endcase
   endfunction

   // every entry that the product reads gets loaded first
   task automatic compute_product();
      for (int a = 0; a < left_size; a++)
         if (!left_written[a]) load_elem(OP_LOAD_LEFT, IDX_W'(a), random_value());
      for (int a = 0; a < right_size; a++)
         if (!right_written[a]) load_elem(OP_LOAD_RIGHT, IDX_W'(a), random_value());
      send_item(OP_COMPUTE, IDX_W'($urandom), random_value());
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // dimension of one may be written as zero, of eight as anything above
   function automatic logic [CSR_DATA_W-1:0] encode_dim(input int unsigned dim);
      if (dim == 1 && $urandom_range(0, 2) == 0) return '0;
      if (dim == MAX_DIM && $urandom_range(0, 1) == 0)
         return CSR_DATA_W'($urandom_range(MAX_DIM + 1, 15));
      return CSR_DATA_W'(dim);
   endfunction

   task automatic program_regs(input int unsigned lr, input int unsigned lc, input int unsigned rr,
                               input int unsigned rc, input logic [MODE_W-1:0] mode);
      csr_write(CSR_LEFT_ROWS, encode_dim(lr));
      csr_write(CSR_LEFT_COLS, encode_dim(lc));
      csr_write(CSR_RIGHT_ROWS, encode_dim(rr));
      csr_write(CSR_RIGHT_COLS, encode_dim(rc));
      csr_write(CSR_MODE, {2'($urandom_range(0, 3)), mode});
      if ($urandom_range(0, 3) == 0) csr_write(CSR_NONE, CSR_DATA_W'($urandom));
      csr_we     <= 1'b0;
      left_size  = lr * lc;
      right_size = rr * rc;
   endtask

   // drop valid, let every expected item arrive, then let the block settle
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic int unsigned pick_dim();
      return ($urandom_range(0, 4) == 0) ? $urandom_range(5, MAX_DIM) : $urandom_range(1, 4);
   endfunction

   // stimulus
   initial begin
      int unsigned   phase, m, n, p, phase_len, pick, size;
      logic [MODE_W-1:0] mode;
      logic          side;
      reset                  <= 1'b1;
      csr_we                 <= 1'b0;
      csr_index              <= CSR_LEFT_ROWS;
      csr_wdata              <= '0;
      req_chan.valid         <= 1'b0;
      req_chan.opcode        <= OP_LOAD_LEFT;
      req_chan.element_index <= '0;
      req_chan.element_value <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // one by one products at reset settings: clipping both ways, ties, ignored items
      load_elem(OP_LOAD_LEFT, IDX_W'(0), 32'sh7FFF_FFFF);
      load_elem(OP_LOAD_RIGHT, IDX_W'(0), 32'sh7FFF_FFFF);
      compute_product();
      load_elem(OP_LOAD_LEFT, IDX_W'(0), 32'sh8000_0000);
      compute_product();
      load_elem(OP_LOAD_RIGHT, IDX_W'(0), 32'sh8000_0000);
      compute_product();
      load_elem(OP_LOAD_LEFT, IDX_W'(0), 32'sh0000_0001);
      load_elem(OP_LOAD_RIGHT, IDX_W'(0), 32'sh0000_8000);
      compute_product();
      load_elem(OP_LOAD_LEFT, IDX_W'(0), -32'sh0000_0001);
      compute_product();
      load_elem(OP_LOAD_LEFT, IDX_W'(63), 32'sh5555_AAAA);
      load_elem(OP_LOAD_RIGHT, IDX_W'(63), 32'shAAAA_5555);
      send_item(OP_UNUSED, IDX_W'(63), -32'sh0000_0001);
      send_item(OP_UNUSED, IDX_W'(0), 32'sh0000_0000);
      compute_product();

      // inner dimension mismatch
      wait_idle();
      program_regs(1, 2, 1, 1, 2'd0);
      compute_product();

      // random phases, each under its own settings
      phase = 0;
      while (sent_count < ITEM_COUNT) begin
         mode = MODE_W'($urandom_range(0, 3));
         if (phase == 2 || phase == 5) begin
            m = MAX_DIM; n = MAX_DIM; p = MAX_DIM;
         end else if (phase == 3) begin
            m = 1; n = 1; p = 1;
         end else begin
            m = pick_dim(); n = pick_dim(); p = pick_dim();
         end
         wait_idle();
         if ($urandom_range(0, 4) == 0)
            program_regs(pick_dim(), pick_dim(), pick_dim(), pick_dim(), mode);
         else
            program_regs(mode[1] ? n : m, mode[1] ? m : n, mode[0] ? p : n, mode[0] ? n : p,
                         mode);
         phase_len = $urandom_range(6, 30);
         repeat (phase_len) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
               send_item(OP_UNUSED, IDX_W'($urandom), random_value());
            end else if (pick <= 6) begin
               compute_product();
            end else begin
               side = 1'($urandom_range(0, 1));
               size = side ? right_size : left_size;
               load_elem(side ? OP_LOAD_RIGHT : OP_LOAD_LEFT,
                         ($urandom_range(0, 9) < 7) ? IDX_W'($urandom_range(0, size - 1))
                                                    : IDX_W'($urandom),
                         random_value());
            end
         end
         phase++;
      end

      wait_idle();
      if (failures == 0) $display("[matrix_multiply_transpose_modes] OK");
      else $display("[matrix_multiply_transpose_modes] ERROR");
      $finish;
   end

   // overall time limit
   initial begin
      #10_000_000;
      $display("[matrix_multiply_transpose_modes] ERROR");
      $finish;
   end

endmodule
